### rtl/mfsp_pkg.sv
`timescale 1ns / 1ps
package mfsp_pkg;

    localparam int IMEM_WORDS_DEF = 256;
    localparam int DMEM_WORDS_DEF = 256;
    localparam int REG_COUNT_DEF  = 32;

    localparam logic [1:0] CMD_LOAD_INSTR = 2'd0;
    localparam logic [1:0] CMD_WRITE_REG  = 2'd1;
    localparam logic [1:0] CMD_WRITE_DATA = 2'd2;
    localparam logic [1:0] CMD_TICK       = 2'd3;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_ORI   = 6'b001101;
    localparam logic [5:0] FN_ADD   = 6'b100000;
    localparam logic [5:0] FN_SUB   = 6'b100010;
    localparam logic [5:0] FN_AND   = 6'b100100;
    localparam logic [5:0] FN_OR    = 6'b100101;

    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SUB  = 3'd1;
    localparam logic [2:0] ALU_AND  = 3'd2;
    localparam logic [2:0] ALU_OR   = 3'd3;
    localparam logic [2:0] ALU_ZERO = 3'd4;

    typedef struct packed {
        logic        valid;
        logic        regw;
        logic        m2r;
        logic        branch;
        logic        use_imm;
        logic [2:0]  aluop;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [9:0]  pc4;
    } t_dx;

    typedef struct packed {
        logic        valid;
        logic        regw;
        logic        m2r;
        logic        branch;
        logic [31:0] alu;
        logic [4:0]  dest;
        logic [9:0]  target;
    } t_xm;

    typedef struct packed {
        logic        valid;
        logic        regw;
        logic        m2r;
        logic [31:0] alu;
        logic [31:0] rdata;
        logic [4:0]  dest;
    } t_mw;

    typedef struct packed {
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
        logic [9:0]  fetch_pc;
        logic        branch_taken;
        logic        drained;
    } t_res;

endpackage

### rtl/mfsp_ram.sv
`timescale 1ns / 1ps
module mfsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/mfsp_store.sv
`timescale 1ns / 1ps
module mfsp_store #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [DEPTH-1:0] r_vld;
    logic             r_rvld;
    logic             r_byp;
    logic [WIDTH-1:0] r_bdata;
    logic [WIDTH-1:0] ram_q;
    logic             hit;

    assign hit = i_we && (i_waddr == i_raddr);

    mfsp_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr] || hit;
            r_byp  <= hit;
        end
        r_bdata <= i_wdata;
    end

    assign o_rdata = !r_rvld ? '0 : (r_byp ? r_bdata : ram_q);
endmodule

### rtl/mips_five_stage_pipeline_subset_unit.sv
`timescale 1ns / 1ps
// Five-stage MIPS subset pipeline driven by command beats.
// Input channel (i_valid / o_ready) carries i_command, i_address, i_data:
// load an instruction word, write a register, write a data word, or tick
// the pipeline. Every input beat yields exactly one result beat
// on the output channel (o_valid / i_ready); non-tick beats give all-zero
// results.
// A result is registered in the output buffer when its input beat is taken.
// Throughput: one beat per cycle while o_ready is high; the whole tick is
// evaluated from the pipeline registers and the registered reads of
// instruction memory, data memory and register file, which are prefetched
// at the addresses the next state will need.
// A two-entry output buffer (result register plus skid) keeps input
// accepted while one result waits; o_ready drops only when both are full.
// Reset (synchronous, active low) clears the pipeline to bubbles, the PC to
// zero and all memories to zero through per-entry valid bits.
module mips_five_stage_pipeline_subset_unit #(
    parameter int IMEM_WORDS = mfsp_pkg::IMEM_WORDS_DEF,
    parameter int DMEM_WORDS = mfsp_pkg::DMEM_WORDS_DEF,
    parameter int REG_COUNT  = mfsp_pkg::REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_address,
    input  logic [31:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_wb_valid,
    output logic [4:0]  o_wb_reg,
    output logic signed [31:0] o_wb_value,
    output logic [9:0]  o_fetch_pc,
    output logic        o_branch_taken,
    output logic        o_drained
);
    localparam int IAW = $clog2(IMEM_WORDS);
    localparam int DAW = $clog2(DMEM_WORDS);
    localparam int RAW = $clog2(REG_COUNT);

    logic [9:0]      r_pc, n_pc;
    logic [31:0]     r_fd_word, n_fd_word;
    logic [9:0]      r_fd_pc4, n_fd_pc4;
    mfsp_pkg::t_dx   r_dx, n_dx;
    mfsp_pkg::t_xm   r_xm, n_xm;
    mfsp_pkg::t_mw   r_mw, n_mw;
    logic            r_first;
    mfsp_pkg::t_res  n_res, r_out, r_skid;
    logic            r_out_valid, r_skid_valid;

    logic            acc, tick, stall, taken, mw_wb;
    logic [31:0]     wbv, ex_a, ex_b, ex_s, ex_r, rd_a, rd_b;
    logic [4:0]      fd_rs, fd_rt;
    logic [5:0]      op, fn;
    logic [15:0]     imm16;
    logic [31:0]     im_q, dm_q, rfa_q, rfb_q, fetch_word;
    logic [11:0]     im_waddr_w, im_raddr_w, dm_waddr_w;
    logic            im_we, dm_we, rf_we;
    logic [RAW-1:0]  rf_waddr;
    logic [31:0]     rf_wdata;

    assign acc     = i_valid && o_ready;
    assign o_ready = !r_skid_valid;
    assign tick    = acc && (i_command == mfsp_pkg::CMD_TICK);

    assign mw_wb = r_mw.valid && r_mw.regw;
    assign wbv   = r_mw.m2r ? r_mw.rdata : r_mw.alu;
    assign fd_rs = r_fd_word[25:21];
    assign fd_rt = r_fd_word[20:16];
    assign op    = r_fd_word[31:26];
    assign fn    = r_fd_word[5:0];
    assign imm16 = r_fd_word[15:0];

    always_comb begin
        if (r_xm.valid && r_xm.regw && r_xm.dest == r_dx.rs) begin
            ex_a = r_xm.alu;
        end else if (mw_wb && r_mw.dest == r_dx.rs) begin
            ex_a = wbv;
        end else begin
            ex_a = r_dx.a;
        end
        if (r_xm.valid && r_xm.regw && r_xm.dest == r_dx.rt) begin
            ex_b = r_xm.alu;
        end else if (mw_wb && r_mw.dest == r_dx.rt) begin
            ex_b = wbv;
        end else begin
            ex_b = r_dx.b;
        end
        ex_s = r_dx.use_imm ? r_dx.imm : ex_b;
        case (r_dx.aluop)
            mfsp_pkg::ALU_ADD: ex_r = ex_a + ex_s;
            mfsp_pkg::ALU_SUB: ex_r = ex_a - ex_s;
            mfsp_pkg::ALU_AND: ex_r = ex_a & ex_s;
            mfsp_pkg::ALU_OR:  ex_r = ex_a | ex_s;
            default:           ex_r = '0;
        endcase
    end

    always_comb begin
        if (fd_rs == 5'd0 || 32'(fd_rs) >= REG_COUNT) begin
            rd_a = '0;
        end else if (mw_wb && r_mw.dest == fd_rs) begin
            rd_a = wbv;
        end else begin
            rd_a = rfa_q;
        end
        if (fd_rt == 5'd0 || 32'(fd_rt) >= REG_COUNT) begin
            rd_b = '0;
        end else if (mw_wb && r_mw.dest == fd_rt) begin
            rd_b = wbv;
        end else begin
            rd_b = rfb_q;
        end
    end

    assign fetch_word = (32'(r_pc[9:2]) < IMEM_WORDS) ? im_q : '0;

    always_comb begin
        n_mw       = '0;
        n_mw.valid = r_xm.valid;
        n_mw.regw  = r_xm.valid && r_xm.regw;
        n_mw.m2r   = r_xm.m2r;
        n_mw.alu   = r_xm.alu;
        n_mw.dest  = r_xm.dest;
        if (r_xm.valid && r_xm.m2r && (r_xm.alu[31:2] < 30'(DMEM_WORDS))) begin
            n_mw.rdata = dm_q;
        end
        taken = r_xm.valid && r_xm.branch && (r_xm.alu == 32'd0);

        n_xm        = '0;
        n_xm.valid  = r_dx.valid;
        n_xm.regw   = r_dx.valid && r_dx.regw;
        n_xm.m2r    = r_dx.m2r;
        n_xm.branch = r_dx.branch;
        n_xm.alu    = ex_r;
        n_xm.dest   = r_dx.dest;
        n_xm.target = r_dx.pc4 + {r_dx.imm[7:0], 2'b00};

        stall = r_dx.valid && r_dx.regw && r_dx.m2r
                && (r_dx.dest == fd_rs || r_dx.dest == fd_rt);

        n_dx       = '0;
        n_dx.rs    = fd_rs;
        n_dx.rt    = fd_rt;
        n_dx.a     = rd_a;
        n_dx.b     = rd_b;
        n_dx.pc4   = r_fd_pc4;
        n_dx.imm   = {{16{imm16[15]}}, imm16};
        n_dx.aluop = mfsp_pkg::ALU_ADD;
        case (op)
            mfsp_pkg::OP_RTYPE: begin
                if (!(fn == 6'd0 && fd_rs == 5'd0 && fd_rt == 5'd0)) begin
                    n_dx.valid = 1'b1;
                    n_dx.dest  = r_fd_word[15:11];
                    n_dx.regw  = (r_fd_word[15:11] != 5'd0)
                                 && (32'(r_fd_word[15:11]) < REG_COUNT);
                    case (fn)
                        mfsp_pkg::FN_ADD: n_dx.aluop = mfsp_pkg::ALU_ADD;
                        mfsp_pkg::FN_SUB: n_dx.aluop = mfsp_pkg::ALU_SUB;
                        mfsp_pkg::FN_AND: n_dx.aluop = mfsp_pkg::ALU_AND;
                        mfsp_pkg::FN_OR:  n_dx.aluop = mfsp_pkg::ALU_OR;
                        default:          n_dx.aluop = mfsp_pkg::ALU_ZERO;
                    endcase
                end
            end
            mfsp_pkg::OP_LW, mfsp_pkg::OP_ADDI, mfsp_pkg::OP_ORI: begin
                n_dx.valid   = 1'b1;
                n_dx.use_imm = 1'b1;
                n_dx.dest    = fd_rt;
                n_dx.regw    = (fd_rt != 5'd0) && (32'(fd_rt) < REG_COUNT);
                n_dx.m2r     = (op == mfsp_pkg::OP_LW);
                if (op == mfsp_pkg::OP_ORI) begin
                    n_dx.aluop = mfsp_pkg::ALU_OR;
                    n_dx.imm   = {16'd0, imm16};
                end
            end
            mfsp_pkg::OP_BEQ: begin
                n_dx.valid  = 1'b1;
                n_dx.branch = 1'b1;
                n_dx.aluop  = mfsp_pkg::ALU_SUB;
            end
            default: begin
                n_dx.valid = 1'b0;
            end
        endcase
        if (stall) begin
            n_dx = '0;
        end

        if (stall) begin
            n_fd_word = r_fd_word;
            n_fd_pc4  = r_fd_pc4;
            n_pc      = r_pc;
        end else begin
            n_fd_word = fetch_word;
            n_fd_pc4  = r_pc + 10'd4;
            n_pc      = r_pc + 10'd4;
        end

        if (taken) begin
            n_pc      = r_xm.target;
            n_fd_word = '0;
            n_fd_pc4  = '0;
            n_dx      = '0;
            n_xm      = '0;
        end

        n_res = '0;
        if (i_command == mfsp_pkg::CMD_TICK) begin
            n_res.wb_valid     = mw_wb;
            n_res.wb_reg       = mw_wb ? r_mw.dest : 5'd0;
            n_res.wb_value     = mw_wb ? wbv : 32'd0;
            n_res.fetch_pc     = r_pc;
            n_res.branch_taken = taken;
            n_res.drained      = !r_first && !n_dx.valid && !n_xm.valid && !n_mw.valid;
        end
    end

    always_comb begin
        im_waddr_w = {4'd0, i_address};
        dm_waddr_w = {4'd0, i_address};
        im_raddr_w = tick ? {4'd0, n_pc[9:2]} : {4'd0, r_pc[9:2]};
        im_we = acc && (i_command == mfsp_pkg::CMD_LOAD_INSTR)
                && (32'(i_address) < IMEM_WORDS);
        dm_we = acc && (i_command == mfsp_pkg::CMD_WRITE_DATA)
                && (32'(i_address) < DMEM_WORDS);
        if (tick) begin
            rf_we    = mw_wb;
            rf_waddr = r_mw.dest[RAW-1:0];
            rf_wdata = wbv;
        end else begin
            rf_we    = acc && (i_command == mfsp_pkg::CMD_WRITE_REG)
                       && (i_address != 8'd0) && (32'(i_address) < REG_COUNT);
            rf_waddr = i_address[RAW-1:0];
            rf_wdata = i_data;
        end
    end

    mfsp_store #(.WIDTH(32), .DEPTH(IMEM_WORDS)) u_imem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (im_we),
        .i_waddr (im_waddr_w[IAW-1:0]),
        .i_wdata (i_data),
        .i_raddr (im_raddr_w[IAW-1:0]),
        .o_rdata (im_q)
    );

    mfsp_store #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dm_we),
        .i_waddr (dm_waddr_w[DAW-1:0]),
        .i_wdata (i_data),
        .i_raddr (tick ? n_xm.alu[DAW+1:2] : r_xm.alu[DAW+1:2]),
        .o_rdata (dm_q)
    );

    mfsp_store #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (tick ? n_fd_word[21+RAW-1:21] : r_fd_word[21+RAW-1:21]),
        .o_rdata (rfa_q)
    );

    mfsp_store #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (tick ? n_fd_word[16+RAW-1:16] : r_fd_word[16+RAW-1:16]),
        .o_rdata (rfb_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_fd_word <= '0;
            r_fd_pc4  <= '0;
            r_dx      <= '0;
            r_xm      <= '0;
            r_mw      <= '0;
            r_first   <= 1'b1;
        end else if (tick) begin
            r_pc      <= n_pc;
            r_fd_word <= n_fd_word;
            r_fd_pc4  <= n_fd_pc4;
            r_dx      <= n_dx;
            r_xm      <= n_xm;
            r_mw      <= n_mw;
            r_first   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (acc) begin
                r_out <= n_res;
            end
        end else if (acc) begin
            r_skid <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_wb_valid     = r_out.wb_valid;
    assign o_wb_reg       = r_out.wb_reg;
    assign o_wb_value     = r_out.wb_value;
    assign o_fetch_pc     = r_out.fetch_pc;
    assign o_branch_taken = r_out.branch_taken;
    assign o_drained      = r_out.drained;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick && taken) |=> (r_fd_word == 32'd0 && !r_dx.valid && !r_xm.valid))
        else $error("taken branch did not flush younger stages");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick && stall && !taken) |=> (r_pc == $past(r_pc) && !r_dx.valid))
        else $error("load-use stall did not hold fetch");

    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xm.valid && r_xm.regw) |-> (r_xm.dest != 5'd0))
        else $error("register zero marked as write target");
endmodule
